// File: hdl/itoa_pkg.sv
package itoa_pkg;

   // word width of the conversion
   localparam int VALUE_BITS = 32;
   localparam int VALUE_IN_BITS = 32;
   localparam int RADIX_BITS = 5;
   localparam int CHAR_BITS = 7;

   // deepest digit stack: every bit of a radix-2 conversion
   localparam int STACK_DEPTH = VALUE_BITS;
   localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);
   localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

   localparam logic [CHAR_BITS-1:0] CH_ZERO  = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0] CH_A     = CHAR_BITS'(97);
   localparam logic [CHAR_BITS-1:0] CH_MINUS = CHAR_BITS'(45);
   localparam logic [3:0]           DEC_TEN  = 4'd10;

   typedef logic [3:0] digit_type;

   // map one digit to its lowercase ASCII code
   function automatic logic [CHAR_BITS-1:0] digit_to_char(input digit_type d);
      logic [CHAR_BITS-1:0] c;
      if (d >= DEC_TEN) begin
         c = CH_A + CHAR_BITS'(d - DEC_TEN);
      end else begin
         c = CH_ZERO + CHAR_BITS'(d);
      end
      return c;
   endfunction

endpackage

// File: hdl/integer_to_radix_ascii_core.sv
// Integer to ASCII conversion in radix 2 to 16.
// Input channel req_*: one transfer carries a value, a radix and a signed
// flag. req_stall stays high from the accepting edge until the last digit
// of that value has been computed and the character stream is drained from
// the digit stack, so only one conversion is in flight.
// Result channel rsp_*: one transfer per character, most significant
// first, '-' leading for a negative signed value, rsp_last on the final one.
// Radix 0/1 acts as 2, radix 17..31 acts as 16.
// Each digit is one bit-serial long division of the whole word by the
// radix through a 5-bit remainder stage. All digits of an item are
// divided out first, then one character is sent per cycle while
// rsp_stall is low, with one more character for a sign; radix 2 of a
// full word is the worst case.
// A stall on rsp_ holds the output register and freezes the drain; the
// division keeps running. A new item is taken once the stack has been
// emptied into the output register, even while the final character waits.
// Reset (synchronous, active high) empties the output register and returns
// the sequencer to idle; the digit stack needs no clearing.
module integer_to_radix_ascii_core
   import itoa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [VALUE_IN_BITS-1:0] req_value,
   input  logic [RADIX_BITS-1:0]    req_radix,
   input  logic                     req_signed_mode,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CHAR_BITS-1:0]     rsp_character,
   output logic                     rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [VALUE_BITS-1:0]     quot_ff, quot_in;
   logic [3:0]                rem_ff, rem_in;
   logic [RADIX_BITS-1:0]     base_ff, base_in;
   logic                      neg_ff, neg_in;
   logic                      nz_ff, nz_in;
   logic [BIT_CNT_BITS-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DEPTH_BITS-1:0]     depth_ff, depth_in;
   digit_type                 stack_ff [STACK_DEPTH];
   digit_type                 stack_in [STACK_DEPTH];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]      rsp_character_ff, rsp_character_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_xfer;
   logic                      out_free;
   logic [VALUE_BITS-1:0]     word;
   logic [RADIX_BITS-1:0]     rem_shift;
   logic                      rem_ge;
   logic [RADIX_BITS-1:0]     rem_next;
   logic                      last_bit;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_xfer      = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   assign word = VALUE_BITS'(req_value);

   // one restoring step of the long division: bring down the next bit
   assign rem_shift = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign rem_ge    = (rem_shift >= base_ff);
   assign rem_next  = rem_ge ? (rem_shift - base_ff) : rem_shift;
   assign last_bit  = (bit_cnt_ff == BIT_CNT_BITS'(VALUE_BITS - 1));

   always_comb begin
      state_in         = state_ff;
      quot_in          = quot_ff;
      rem_in           = rem_ff;
      base_in          = base_ff;
      neg_in           = neg_ff;
      nz_in            = nz_ff;
      bit_cnt_in       = bit_cnt_ff;
      depth_in         = depth_ff;
      stack_in         = stack_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // saturate the radix into 2..16
               if (req_radix < RADIX_MIN) begin
                  base_in = RADIX_MIN;
               end else if (req_radix > RADIX_MAX) begin
                  base_in = RADIX_MAX;
               end else begin
                  base_in = req_radix;
               end
               neg_in     = req_signed_mode && word[VALUE_BITS-1];
               quot_in    = neg_in ? (~word + VALUE_BITS'(1)) : word;
               rem_in     = '0;
               nz_in      = 1'b0;
               bit_cnt_in = '0;
               depth_in   = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in    = {quot_ff[VALUE_BITS-2:0], rem_ge};
            rem_in     = rem_next[3:0];
            nz_in      = nz_ff || rem_ge;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_BITS'(1);
            if (last_bit) begin
               // push the finished digit, restart on the quotient
               for (int i = STACK_DEPTH - 1; i > 0; i--) begin
                  stack_in[i] = stack_ff[i-1];
               end
               stack_in[0] = rem_next[3:0];
               depth_in    = depth_ff + DEPTH_BITS'(1);
               rem_in      = '0;
               nz_in       = 1'b0;
               bit_cnt_in  = '0;
               if (!(nz_ff || rem_ge)) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = CH_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               // pop the top digit into the output register
               rsp_valid_in     = 1'b1;
               rsp_character_in = digit_to_char(stack_ff[0]);
               rsp_last_in      = (depth_ff == DEPTH_BITS'(1));
               for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               depth_in = depth_ff - DEPTH_BITS'(1);
               if (depth_ff == DEPTH_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         bit_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
         bit_cnt_ff   <= bit_cnt_in;
      end
      quot_ff          <= quot_in;
      rem_ff           <= rem_in;
      base_ff          <= base_in;
      neg_ff           <= neg_in;
      nz_ff            <= nz_in;
      stack_ff         <= stack_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   // the remainder never reaches the divisor while dividing
   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < base_ff[3:0] || base_ff == RADIX_MAX))
      else $error("division remainder out of range");

   // draining always has a digit left on the stack
   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (depth_ff != '0))
      else $error("emit with empty digit stack");

   // a new conversion only starts with the stack empty
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (depth_ff == '0))
      else $error("item accepted with digits pending");

   // the final character of a conversion returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && depth_ff == DEPTH_BITS'(1))
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final character not flagged");

endmodule
